@@ hdl/urdiv_pkg.sv @@
// Shared types, constants and the single divide step for the unsigned restoring divider.
// No dependencies; used by urdiv_stage and unsigned_restoring_divider.
package urdiv_pkg;

    localparam int URDIV_DIVIDEND_W      = 32;
    localparam int URDIV_DIVISOR_W       = 16;
    localparam int URDIV_HALF_W          = 16;
    localparam int URDIV_NARROW_W        = 8;
    localparam int URDIV_STEPS_PER_STAGE = 4;

    // Mode bits of op
    localparam int OP_BIT_WIDE_DIVIDEND = 0;
    localparam int OP_BIT_WIDE_DIVISOR  = 1;

    typedef struct packed {
        logic [1:0]                    op;
        logic [URDIV_DIVIDEND_W-1:0]   dividend;
        logic [URDIV_DIVISOR_W-1:0]    divisor;
    } urdiv_in_t;

    typedef struct packed {
        logic [URDIV_DIVIDEND_W-1:0]   quotient;
        logic [URDIV_DIVISOR_W-1:0]    remainder;
    } urdiv_out_t;

    // In-flight state: dividend bits shift out of the top of nq while
    // quotient bits shift in at the bottom.
    typedef struct packed {
        logic [URDIV_DIVISOR_W-1:0]    rem;
        logic [URDIV_DIVIDEND_W-1:0]   nq;
        logic [URDIV_DIVISOR_W-1:0]    divisor;
        logic                          narrow;
        logic                          half;
    } urdiv_work_t;

    function automatic urdiv_work_t urdiv_step(input urdiv_work_t w);
        urdiv_work_t                r;
        logic [URDIV_DIVISOR_W:0]   t;
        logic [URDIV_DIVISOR_W:0]   d;
        logic [URDIV_DIVISOR_W:0]   diff;
        logic [URDIV_DIVISOR_W:0]   sel;
        logic                       ge;
        r    = w;
        t    = {w.rem, w.nq[URDIV_DIVIDEND_W-1]};
        d    = {1'b0, w.divisor};
        diff = t - d;
        ge   = (t >= d);
        sel  = ge ? diff : t;
        // bits shifted past the remainder width are dropped (matters for zero divisor)
        if (w.narrow) begin
            r.rem = {{(URDIV_DIVISOR_W-URDIV_NARROW_W){1'b0}}, sel[URDIV_NARROW_W-1:0]};
        end else begin
            r.rem = sel[URDIV_DIVISOR_W-1:0];
        end
        r.nq = {w.nq[URDIV_DIVIDEND_W-2:0], ge};
        return r;
    endfunction

endpackage

@@ hdl/urdiv_stage.sv @@
// One pipeline stage of the divider: a few restoring steps, then a register with valid.
// Depends on urdiv_pkg.
module urdiv_stage #(
    parameter int STEPS = urdiv_pkg::URDIV_STEPS_PER_STAGE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  urdiv_pkg::urdiv_work_t in_work,
    output logic                  out_valid,
    input  logic                  out_ready,
    output urdiv_pkg::urdiv_work_t out_work
);
    import urdiv_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    urdiv_work_t work_reg;
    urdiv_work_t work_next;
    urdiv_work_t step_work;

    always_comb begin
        step_work = in_work;
        for (int i = 0; i < STEPS; i++) begin
            step_work = urdiv_step(step_work);
        end
    end

    // stage can take a beat when empty or when its content moves on
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = in_ready ? in_valid : valid_reg;
        work_next  = (in_ready && in_valid) ? step_work : work_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule

@@ hdl/unsigned_restoring_divider.sv @@
// Unsigned restoring divider, modes 16/8, 32/8, 16/16 and 32/16, fully pipelined.
// Depends on urdiv_pkg and urdiv_stage.
//
// Input channel s_*: one beat carries op, dividend and divisor (urdiv_in_t).
// Result channel m_*: one beat per input beat with quotient and remainder
// (urdiv_out_t), in input order.
// Every item runs 32 shift-subtract steps; 16-bit dividends are zero-extended,
// which leaves the remainder unchanged, and the quotient is cut to 16 bits.
// STEPS_PER_STAGE steps sit between registers, so the pipeline has
// 32 / STEPS_PER_STAGE stages (8 by default). One beat enters per cycle
// while s_ready is high. The last stage is the output register. When
// m_ready is low, stages hold and empty stages still fill; s_ready drops
// only once every stage holds a beat.
// A zero divisor gives an all-ones quotient at the dividend width and the low
// dividend bits as remainder.
// Reset (aresetn low, synchronous) empties the pipeline.
module unsigned_restoring_divider #(
    parameter int STEPS_PER_STAGE = urdiv_pkg::URDIV_STEPS_PER_STAGE
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  urdiv_pkg::urdiv_in_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output urdiv_pkg::urdiv_out_t m_data
);
    import urdiv_pkg::*;

    localparam int NUM_STAGES = URDIV_DIVIDEND_W / STEPS_PER_STAGE;

    logic        stg_valid [NUM_STAGES+1];
    logic        stg_ready [NUM_STAGES+1];
    urdiv_work_t stg_work  [NUM_STAGES+1];
    urdiv_work_t first_work;
    urdiv_work_t last_work;

    always_comb begin
        first_work.rem     = '0;
        first_work.narrow  = !s_data.op[OP_BIT_WIDE_DIVISOR];
        first_work.half    = !s_data.op[OP_BIT_WIDE_DIVIDEND];
        if (s_data.op[OP_BIT_WIDE_DIVIDEND]) begin
            first_work.nq = s_data.dividend;
        end else begin
            first_work.nq = {{(URDIV_DIVIDEND_W-URDIV_HALF_W){1'b0}},
                             s_data.dividend[URDIV_HALF_W-1:0]};
        end
        if (s_data.op[OP_BIT_WIDE_DIVISOR]) begin
            first_work.divisor = s_data.divisor;
        end else begin
            first_work.divisor = {{(URDIV_DIVISOR_W-URDIV_NARROW_W){1'b0}},
                                  s_data.divisor[URDIV_NARROW_W-1:0]};
        end
    end

    assign stg_work[0]  = first_work;
    assign stg_valid[0] = s_valid;
    assign s_ready      = stg_ready[0];

    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        urdiv_stage #(
            .STEPS (STEPS_PER_STAGE)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_work   (stg_work[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_work  (stg_work[g+1])
        );
    end

    assign stg_ready[NUM_STAGES] = m_ready;
    assign m_valid               = stg_valid[NUM_STAGES];
    assign last_work             = stg_work[NUM_STAGES];

    always_comb begin
        m_data.remainder = last_work.rem;
        if (last_work.half) begin
            m_data.quotient = {{(URDIV_DIVIDEND_W-URDIV_HALF_W){1'b0}},
                               last_work.nq[URDIV_HALF_W-1:0]};
        end else begin
            m_data.quotient = last_work.nq;
        end
    end

endmodule

@@ test/unsigned_restoring_divider_tb.sv @@
// Testbench for unsigned_restoring_divider: a directed table, then random divisions in all
// four width modes under varied source idling and sink stalls, checked by a local predictor.
// Depends on urdiv_pkg and the divider RTL.
`timescale 1ns / 100ps

module unsigned_restoring_divider_tb;
    import urdiv_pkg::*;

    localparam logic [1:0] MODE_16_8  = 2'd0;
    localparam logic [1:0] MODE_32_8  = 2'd1;
    localparam logic [1:0] MODE_16_16 = 2'd2;
    localparam logic [1:0] MODE_32_16 = 2'd3;

    localparam int RESET_CYCLES     = 8;
    localparam int PIPE_LATENCY     = 32 / URDIV_STEPS_PER_STAGE;
    localparam int RANDOM_PER_PHASE = 310;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        urdiv_in_t  beat;
        logic       known;  // result typed in by hand below
        urdiv_out_t want;
    } division_row_t;

    localparam int DIRECTED_ROWS = 22;
    localparam division_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
        '{'{MODE_16_8,  32'h0000_0064, 16'h0007}, 1'b1, '{32'h0000_000E, 16'h0002}},
        '{'{MODE_16_8,  32'hFFFF_FFFF, 16'hFF01}, 1'b1, '{32'h0000_FFFF, 16'h0000}},
        '{'{MODE_16_8,  32'h1234_5678, 16'h0000}, 1'b1, '{32'h0000_FFFF, 16'h0078}},
        '{'{MODE_32_8,  32'h89AB_CDEF, 16'h0000}, 1'b1, '{32'hFFFF_FFFF, 16'h00EF}},
        '{'{MODE_16_16, 32'hDEAD_BEEF, 16'h0000}, 1'b1, '{32'h0000_FFFF, 16'hBEEF}},
        '{'{MODE_32_16, 32'h0123_4567, 16'h0000}, 1'b1, '{32'hFFFF_FFFF, 16'h4567}},
        '{'{MODE_32_16, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1, '{32'h0001_0001, 16'h0000}},
        '{'{MODE_32_8,  32'hFFFF_FFFF, 16'h00FF}, 1'b1, '{32'h0101_0101, 16'h0000}},
        '{'{MODE_16_16, 32'h0000_FFFF, 16'hFFFF}, 1'b1, '{32'h0000_0001, 16'h0000}},
        '{'{MODE_16_8,  32'h0000_0000, 16'h00FF}, 1'b1, '{32'h0000_0000, 16'h0000}},
        '{'{MODE_32_16, 32'h0000_0000, 16'h0000}, 1'b1, '{32'hFFFF_FFFF, 16'h0000}},
        '{'{MODE_32_8,  32'hFFFF_FFFF, 16'h0001}, 1'b1, '{32'hFFFF_FFFF, 16'h0000}},
        '{'{MODE_16_16, 32'h0001_0000, 16'h0003}, 1'b1, '{32'h0000_0000, 16'h0000}},
        '{'{MODE_16_8,  32'h0000_00AB, 16'h0100}, 1'b1, '{32'h0000_FFFF, 16'h00AB}},
        '{'{MODE_32_16, 32'h8000_0000, 16'h8000}, 1'b1, '{32'h0001_0000, 16'h0000}},
        '{'{MODE_32_8,  32'h1234_5678, 16'hFF00}, 1'b1, '{32'hFFFF_FFFF, 16'h0078}},
        '{'{MODE_16_8,  32'hFFFF_1234, 16'h0302}, 1'b1, '{32'h0000_091A, 16'h0000}},
        '{'{MODE_16_8,  32'h0000_0005, 16'h00FF}, 1'b1, '{32'h0000_0000, 16'h0005}},
        '{'{MODE_32_8,  32'hFEDC_BA98, 16'h33A5}, 1'b0, '{32'h0000_0000, 16'h0000}},
        '{'{MODE_16_16, 32'h5A5A_ABCD, 16'h1234}, 1'b0, '{32'h0000_0000, 16'h0000}},
        '{'{MODE_32_16, 32'hFFFF_FFFE, 16'hFFFF}, 1'b0, '{32'h0000_0000, 16'h0000}},
        '{'{MODE_32_16, 32'h0000_FFFF, 16'h8001}, 1'b0, '{32'h0000_0000, 16'h0000}}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    urdiv_in_t  s_data;
    logic       m_valid;
    logic       m_ready;
    urdiv_out_t m_data;

    // travel with the beat on s_data
    logic       beat_known;
    urdiv_out_t beat_want;

    urdiv_out_t  pending_results[$];
    int unsigned mismatch_count;
    int unsigned checked_count;
    int unsigned mode_count[4];
    int unsigned zero_divisor_count;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    unsigned_restoring_divider dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Shift-subtract, one quotient bit per dividend bit, MSB first.
    function automatic urdiv_out_t predict_division(input urdiv_in_t beat);
        urdiv_out_t  res;
        logic        wide_num;
        logic        wide_dvs;
        logic [31:0] num;
        logic [31:0] quo;
        logic [15:0] dvs;
        logic [15:0] part;
        logic [16:0] trial;
        int          steps;
        int          i;
        wide_num = beat.op[OP_BIT_WIDE_DIVIDEND];
        wide_dvs = beat.op[OP_BIT_WIDE_DIVISOR];
        steps    = wide_num ? URDIV_DIVIDEND_W : URDIV_HALF_W;
        num      = wide_num ? beat.dividend : {16'h0000, beat.dividend[15:0]};
        dvs      = wide_dvs ? beat.divisor : {8'h00, beat.divisor[7:0]};
        part     = '0;
        quo      = '0;
        for (i = steps - 1; i >= 0; i--) begin
            trial = {part, num[i]};
            if (trial >= {1'b0, dvs}) begin
                trial = trial - {1'b0, dvs};
                quo   = {quo[30:0], 1'b1};
            end else begin
                quo   = {quo[30:0], 1'b0};
            end
            // overflow past the remainder width is lost
            part = wide_dvs ? trial[15:0] : {8'h00, trial[7:0]};
        end
        res.quotient  = quo;
        res.remainder = part;
        return res;
    endfunction

    function automatic urdiv_in_t random_division();
        urdiv_in_t beat;
        beat.op       = 2'($urandom_range(0, 3));
        beat.dividend = $urandom;
        beat.divisor  = 16'($urandom);
        case ($urandom_range(0, 7))
            0: beat.dividend = $urandom_range(0, 255);
            1: beat.dividend = '1;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            // low byte zero: a zero divisor in 8-bit modes, maybe in all
            0: beat.divisor = {($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'h00, 8'h00};
            1: beat.divisor = 16'($urandom_range(1, 15));
            2: beat.divisor = 16'hFFFF - 16'($urandom_range(0, 3));
            3: beat.divisor = {8'($urandom), 8'($urandom_range(1, 3))};
            default: ;
        endcase
        return beat;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want_v, got_v);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input urdiv_in_t beat, input logic known, input urdiv_out_t want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_data     <= beat;
        beat_known <= known;
        beat_want  <= want;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    // Source holds off until every outstanding result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (pending_results.size() != 0);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        urdiv_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pending_results.push_back(beat_known ? beat_want : predict_division(s_data));
                mode_count[s_data.op]++;
                if (s_data.op[OP_BIT_WIDE_DIVISOR] ? (s_data.divisor == '0)
                                                   : (s_data.divisor[7:0] == 8'h00)) begin
                    zero_divisor_count++;
                end
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result beat", '0, m_data.quotient);
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (m_data.quotient !== want.quotient) begin
                        report_mismatch("quotient", want.quotient, m_data.quotient);
                    end
                    if (m_data.remainder !== want.remainder) begin
                        report_mismatch("remainder", {16'h0000, want.remainder},
                                        {16'h0000, m_data.remainder});
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int          row;
        int          phase;
        int unsigned idle_plan [4][2];
        idle_plan = '{'{0, 0}, '{49, 0}, '{0, 49}, '{30, 30}};
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data             = '0;
        m_ready            = 1'b0;
        beat_known         = 1'b0;
        beat_want          = '0;
        mismatch_count     = 0;
        checked_count      = 0;
        zero_divisor_count = 0;
        cycle_count        = 0;
        mode_count         = '{0, 0, 0, 0};
        send_idle_pct      = 0;
        recv_stall_pct     = 0;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            send_beat(DIRECTED_TABLE[row].beat, DIRECTED_TABLE[row].known,
                      DIRECTED_TABLE[row].want);
        end
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_plan[phase][0];
            recv_stall_pct = idle_plan[phase][1];
            repeat (RANDOM_PER_PHASE) send_beat(random_division(), 1'b0, '0);
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (PIPE_LATENCY + 4) @(posedge aclk);

        $display("checked %0d divisions: %0d at 16/8, %0d at 32/8, %0d at 16/16, %0d at 32/16",
                 checked_count, mode_count[MODE_16_8], mode_count[MODE_32_8],
                 mode_count[MODE_16_16], mode_count[MODE_32_16]);
        $display("%0d by a zero divisor, %0d mismatches", zero_divisor_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/urdiv_pkg.sv
hdl/urdiv_stage.sv
hdl/unsigned_restoring_divider.sv
test/unsigned_restoring_divider_tb.sv
